>>> hw/rtl/i2c_master_transfer_sequencer_defines.svh
// assertion macros shared by the i2c master transfer sequencer rtl
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH

// same-cycle implication, skipped while reset is high
`define I2CMTS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, skipped while reset is high
`define I2CMTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/i2cmts_pkg.sv
// opcodes and bus status codes of the i2c master transfer sequencer
package i2cmts_pkg;

   typedef logic [1:0] opcode_type;
   typedef logic [7:0] status_type;

   // request opcodes
   localparam opcode_type OP_BEGIN_WRITE = 2'd0;
   localparam opcode_type OP_BEGIN_READ  = 2'd1;
   localparam opcode_type OP_BUS_EVENT   = 2'd2;

   // bus controller status codes, low three bits masked off
   localparam status_type ST_BUS_ERROR   = 8'h00;
   localparam status_type ST_START       = 8'h08;
   localparam status_type ST_REP_START   = 8'h10;
   localparam status_type ST_SLA_W_ACK   = 8'h18;
   localparam status_type ST_SLA_W_NACK  = 8'h20;
   localparam status_type ST_DATA_W_ACK  = 8'h28;
   localparam status_type ST_DATA_W_NACK = 8'h30;
   localparam status_type ST_ARB_LOST    = 8'h38;
   localparam status_type ST_SLA_R_ACK   = 8'h40;
   localparam status_type ST_SLA_R_NACK  = 8'h48;
   localparam status_type ST_DATA_R_ACK  = 8'h50;
   localparam status_type ST_DATA_R_NACK = 8'h58;
   localparam status_type ST_NO_INFO     = 8'hf8;

   localparam status_type STATUS_MASK    = 8'hf8;
   localparam logic [7:0] DIR_READ_BIT   = 8'h01;
   localparam logic [7:0] DIR_WRITE_MASK = 8'hfe;

endpackage

>>> hw/rtl/i2c_master_transfer_sequencer.sv
// i2c master transfer sequencer: start requests and bus status events to control words
//
// Takes one request word per clock while req_ready is high: a write start, a read start or a bus status
// event from the bus controller, and returns exactly one result word for each,
// in order. A request is captured in an input register; the next cycle the
// decision logic reads it together with the transfer state (phase, peer address,
// bytes left, buffer position, hold and nack flags), updates that state and
// loads the result register when that register is free or being drained.
// With rsp_ready held high the block sustains one word per clock; a single
// decision step lies between the input and result registers. When the result
// register is full and not taken, the word in the input register waits and
// req_ready drops only once that register is full too.
// A start while a transfer is busy is ignored (result carries only busy and
// nack status); a write of length zero is an address probe.
`include "i2c_master_transfer_sequencer_defines.svh"

module i2c_master_transfer_sequencer (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_target_address,
   input  logic [7:0] req_transfer_length,
   input  logic       req_hold_bus,
   input  logic [7:0] req_status_code,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] req_tx_byte,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_control_write,
   output logic       rsp_send_start,
   output logic       rsp_send_stop,
   output logic       rsp_ack_next,
   output logic       rsp_data_out_valid,
   output logic [7:0] rsp_data_out,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_byte_out,
   output logic [7:0] rsp_buffer_index,
   output logic       rsp_busy_res,
   output logic       rsp_nacked
);

   // transfer phase
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_REQ_WRITE,
      PH_REQ_READ,
      PH_RUNNING
   } phase_type;

   // input register
   logic       in_valid_ff;
   logic [1:0] in_opcode_ff;
   logic [7:0] in_address_ff;
   logic [7:0] in_length_ff;
   logic       in_hold_ff;
   logic [7:0] in_status_ff;
   logic [7:0] in_rx_byte_ff;
   logic [7:0] in_tx_byte_ff;

   // transfer state
   phase_type  phase_ff,     phase_in;
   logic [7:0] peer_addr_ff, peer_addr_in;
   logic [7:0] remain_ff,    remain_in;
   logic       no_stop_ff,   no_stop_in;
   logic       nack_ff,      nack_in;
   logic [7:0] position_ff,  position_in;

   // result register
   logic       out_valid_ff;
   logic       cw_ff,   cw_in;
   logic       sta_ff,  sta_in;
   logic       sto_ff,  sto_in;
   logic       ack_ff,  ack_in;
   logic       dv_ff,   dv_in;
   logic [7:0] dout_ff, dout_in;
   logic       rv_ff,   rv_in;
   logic [7:0] rout_ff, rout_in;
   logic [7:0] bidx_ff, bidx_in;

   logic       advance;
   logic [7:0] status_masked;
   logic [7:0] remain_dec;
   logic [7:0] position_inc;

   // result register free or being drained this cycle
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   assign status_masked = in_status_ff & i2cmts_pkg::STATUS_MASK;
   assign remain_dec    = remain_ff - 8'd1;
   assign position_inc  = position_ff + 8'd1;

   // decision step for the word in the input register
   always_comb begin
      phase_in     = phase_ff;
      peer_addr_in = peer_addr_ff;
      remain_in    = remain_ff;
      no_stop_in   = no_stop_ff;
      nack_in      = nack_ff;
      position_in  = position_ff;
      cw_in        = 1'b0;
      sta_in       = 1'b0;
      sto_in       = 1'b0;
      ack_in       = 1'b0;
      dv_in        = 1'b0;
      dout_in      = 8'd0;
      rv_in        = 1'b0;
      rout_in      = 8'd0;
      bidx_in      = 8'd0;

      if (in_opcode_ff == i2cmts_pkg::OP_BEGIN_WRITE ||
          in_opcode_ff == i2cmts_pkg::OP_BEGIN_READ) begin
         // starts only count while idle
         if (phase_ff == PH_IDLE) begin
            remain_in   = in_length_ff;
            nack_in     = 1'b0;
            position_in = 8'd0;
            cw_in       = 1'b1;
            sta_in      = 1'b1;
            if (in_opcode_ff == i2cmts_pkg::OP_BEGIN_WRITE) begin
               peer_addr_in = in_address_ff & i2cmts_pkg::DIR_WRITE_MASK;
               no_stop_in   = in_hold_ff;
               phase_in     = PH_REQ_WRITE;
            end else begin
               peer_addr_in = in_address_ff | i2cmts_pkg::DIR_READ_BIT;
               no_stop_in   = 1'b0;
               phase_in     = PH_REQ_READ;
            end
         end
      end else if (in_opcode_ff == i2cmts_pkg::OP_BUS_EVENT &&
                   status_masked != i2cmts_pkg::ST_NO_INFO) begin
         cw_in = 1'b1;
         unique case (status_masked)
            i2cmts_pkg::ST_START, i2cmts_pkg::ST_REP_START: begin
               // send address with direction
               if (phase_ff == PH_REQ_WRITE) begin
                  dv_in   = 1'b1;
                  dout_in = peer_addr_ff & i2cmts_pkg::DIR_WRITE_MASK;
               end else if (phase_ff == PH_REQ_READ) begin
                  dv_in   = 1'b1;
                  dout_in = peer_addr_ff | i2cmts_pkg::DIR_READ_BIT;
               end
            end
            i2cmts_pkg::ST_SLA_W_ACK, i2cmts_pkg::ST_DATA_W_ACK: begin
               if (status_masked == i2cmts_pkg::ST_SLA_W_ACK) begin
                  phase_in = PH_RUNNING;
               end
               if (remain_ff != 8'd0) begin
                  dv_in       = 1'b1;
                  dout_in     = in_tx_byte_ff;
                  bidx_in     = position_ff;
                  position_in = position_inc;
                  remain_in   = remain_dec;
               end else begin
                  // probe always stops, a finished write stops unless held
                  sto_in   = (status_masked == i2cmts_pkg::ST_SLA_W_ACK) || !no_stop_ff;
                  phase_in = PH_IDLE;
               end
            end
            i2cmts_pkg::ST_SLA_W_NACK, i2cmts_pkg::ST_DATA_W_NACK,
            i2cmts_pkg::ST_SLA_R_NACK: begin
               sto_in   = 1'b1;
               phase_in = PH_IDLE;
               nack_in  = 1'b1;
            end
            i2cmts_pkg::ST_ARB_LOST: begin
               sta_in = 1'b1;
            end
            i2cmts_pkg::ST_SLA_R_ACK: begin
               phase_in = PH_RUNNING;
               ack_in   = (remain_ff > 8'd1);
            end
            i2cmts_pkg::ST_DATA_R_ACK, i2cmts_pkg::ST_DATA_R_NACK: begin
               if (remain_ff != 8'd0) begin
                  rv_in       = 1'b1;
                  rout_in     = in_rx_byte_ff;
                  bidx_in     = position_ff;
                  position_in = position_inc;
                  remain_in   = remain_dec;
               end
               if (status_masked == i2cmts_pkg::ST_DATA_R_ACK) begin
                  ack_in = (remain_in > 8'd1);
               end else begin
                  sto_in   = !no_stop_ff;
                  phase_in = PH_IDLE;
               end
            end
            i2cmts_pkg::ST_BUS_ERROR: begin
               sto_in   = 1'b1;
               ack_in   = 1'b1;
               phase_in = PH_IDLE;
            end
            default: begin
               // unknown status: bare control write
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_opcode_ff  <= req_opcode;
         in_address_ff <= req_target_address;
         in_length_ff  <= req_transfer_length;
         in_hold_ff    <= req_hold_bus;
         in_status_ff  <= req_status_code;
         in_rx_byte_ff <= req_rx_byte;
         in_tx_byte_ff <= req_tx_byte;
      end
   end

   // transfer state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         peer_addr_ff <= 8'd0;
         remain_ff    <= 8'd0;
         no_stop_ff   <= 1'b0;
         nack_ff      <= 1'b0;
         position_ff  <= 8'd0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            phase_ff     <= phase_in;
            peer_addr_ff <= peer_addr_in;
            remain_ff    <= remain_in;
            no_stop_ff   <= no_stop_in;
            nack_ff      <= nack_in;
            position_ff  <= position_in;
         end
      end
      if (advance && in_valid_ff) begin
         cw_ff   <= cw_in;
         sta_ff  <= sta_in;
         sto_ff  <= sto_in;
         ack_ff  <= ack_in;
         dv_ff   <= dv_in;
         dout_ff <= dout_in;
         rv_ff   <= rv_in;
         rout_ff <= rout_in;
         bidx_ff <= bidx_in;
      end
   end

   // busy and nack reflect the state right after the word, held with it
   logic busy_ff;
   logic nacked_ff;
   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         busy_ff   <= (phase_in != PH_IDLE);
         nacked_ff <= nack_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_control_write  = cw_ff;
   assign rsp_send_start     = sta_ff;
   assign rsp_send_stop      = sto_ff;
   assign rsp_ack_next       = ack_ff;
   assign rsp_data_out_valid = dv_ff;
   assign rsp_data_out       = dout_ff;
   assign rsp_rx_valid       = rv_ff;
   assign rsp_rx_byte_out    = rout_ff;
   assign rsp_buffer_index   = bidx_ff;
   assign rsp_busy_res       = busy_ff;
   assign rsp_nacked         = nacked_ff;

   // both registers full and result stalled: no new request
   `I2CMTS_ASSERT_NOW(a_stall_blocks, clock, reset, in_valid_ff && out_valid_ff && !rsp_ready, !req_ready, "request taken while both stages are full")
   // a word never both sends and stores a data byte
   `I2CMTS_ASSERT_NOW(a_tx_rx_excl, clock, reset, rsp_valid, !(rsp_rx_valid && rsp_data_out_valid), "result sends and stores a byte at once")
   // every start, stop, data or store comes with a control write
   `I2CMTS_ASSERT_NOW(a_action_cw, clock, reset, rsp_valid && (rsp_send_start || rsp_send_stop || rsp_data_out_valid || rsp_rx_valid), rsp_control_write, "bus action without control write")
   // a write start taken while idle enters the write-requested phase
   `I2CMTS_ASSERT_NEXT(a_write_start, clock, reset, advance && in_valid_ff && in_opcode_ff == i2cmts_pkg::OP_BEGIN_WRITE && phase_ff == PH_IDLE, phase_ff == PH_REQ_WRITE && busy_ff, "write start did not enter request phase")

endmodule

>>> sim/i2c_master_transfer_sequencer_tb.sv
// self-checking testbench for the i2c master transfer sequencer
module i2c_master_transfer_sequencer_tb;
   import i2cmts_pkg::*;

   // codes the package leaves out but the stimulus needs
   localparam opcode_type OP_UNUSED   = 2'd3;
   localparam status_type ST_UNLISTED = 8'h60;

   // transfer phase as the sequencer tracks it
   typedef enum logic [1:0] {
      XFER_IDLE,
      XFER_WANT_WRITE,
      XFER_WANT_READ,
      XFER_RUNNING
   } xfer_phase_type;

   // one request word
   typedef struct packed {
      opcode_type opcode;
      logic [7:0] target_address;
      logic [7:0] transfer_length;
      logic       hold_bus;
      status_type status_code;
      logic [7:0] rx_byte;
      logic [7:0] tx_byte;
   } req_word_type;

   // one control word coming back
   typedef struct packed {
      logic       control_write;
      logic       send_start;
      logic       send_stop;
      logic       ack_next;
      logic       data_out_valid;
      logic [7:0] data_out;
      logic       rx_valid;
      logic [7:0] rx_byte_out;
      logic [7:0] buffer_index;
      logic       busy;
      logic       nacked;
   } ctrl_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_opcode = '0;
   logic [7:0] req_target_address = '0;
   logic [7:0] req_transfer_length = '0;
   logic       req_hold_bus = 1'b0;
   logic [7:0] req_status_code = '0;
   logic [7:0] req_rx_byte = '0;
   logic [7:0] req_tx_byte = '0;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_control_write;
   logic       rsp_send_start;
   logic       rsp_send_stop;
   logic       rsp_ack_next;
   logic       rsp_data_out_valid;
   logic [7:0] rsp_data_out;
   logic       rsp_rx_valid;
   logic [7:0] rsp_rx_byte_out;
   logic [7:0] rsp_buffer_index;
   logic       rsp_busy_res;
   logic       rsp_nacked;

   // idling knobs, in percent of cycles
   int unsigned sender_idle_pct = 0;
   int unsigned rsp_stall_pct   = 0;
   logic        rsp_hold_off    = 1'b0;

   int unsigned items_sent     = 0;
   int unsigned mismatch_count = 0;

   // control words predicted for accepted requests, oldest first
   ctrl_word_type pending_control_words[$];

   // predicted sequencer state
   xfer_phase_type mdl_phase    = XFER_IDLE;
   logic [7:0]     mdl_peer     = '0;
   logic [7:0]     mdl_left     = '0;
   logic           mdl_no_stop  = 1'b0;
   logic           mdl_nack     = 1'b0;
   logic [7:0]     mdl_position = '0;

   // codes the random part draws bus events from
   status_type known_codes[13] = '{
      ST_BUS_ERROR, ST_START, ST_REP_START, ST_SLA_W_ACK, ST_SLA_W_NACK,
      ST_DATA_W_ACK, ST_DATA_W_NACK, ST_ARB_LOST, ST_SLA_R_ACK, ST_SLA_R_NACK,
      ST_DATA_R_ACK, ST_DATA_R_NACK, ST_NO_INFO
   };

   i2c_master_transfer_sequencer i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_target_address  (req_target_address),
      .req_transfer_length (req_transfer_length),
      .req_hold_bus        (req_hold_bus),
      .req_status_code     (req_status_code),
      .req_rx_byte         (req_rx_byte),
      .req_tx_byte         (req_tx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_control_write   (rsp_control_write),
      .rsp_send_start      (rsp_send_start),
      .rsp_send_stop       (rsp_send_stop),
      .rsp_ack_next        (rsp_ack_next),
      .rsp_data_out_valid  (rsp_data_out_valid),
      .rsp_data_out        (rsp_data_out),
      .rsp_rx_valid        (rsp_rx_valid),
      .rsp_rx_byte_out     (rsp_rx_byte_out),
      .rsp_buffer_index    (rsp_buffer_index),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_nacked          (rsp_nacked)
   );

   always #5 clock = ~clock;

   // advance the predicted state by one request word and give its control word
   function automatic ctrl_word_type next_control_word(req_word_type w);
      ctrl_word_type c;
      status_type    st;
      c  = '0;
      st = w.status_code & STATUS_MASK;
      if (w.opcode == OP_BEGIN_WRITE || w.opcode == OP_BEGIN_READ) begin
         // starts only count while idle, otherwise they are dropped
         if (mdl_phase == XFER_IDLE) begin
            if (w.opcode == OP_BEGIN_WRITE) begin
               mdl_peer    = w.target_address & DIR_WRITE_MASK;
               mdl_no_stop = w.hold_bus;
               mdl_phase   = XFER_WANT_WRITE;
            end else begin
               mdl_peer    = w.target_address | DIR_READ_BIT;
               mdl_no_stop = 1'b0;
               mdl_phase   = XFER_WANT_READ;
            end
            mdl_left        = w.transfer_length;
            mdl_nack        = 1'b0;
            mdl_position    = '0;
            c.control_write = 1'b1;
            c.send_start    = 1'b1;
         end
      end else if (w.opcode == OP_BUS_EVENT && st != ST_NO_INFO) begin
         c.control_write = 1'b1;
         case (st)
            ST_START, ST_REP_START: begin
               // address byte goes out only if a start was requested
               if (mdl_phase == XFER_WANT_WRITE) begin
                  c.data_out_valid = 1'b1;
                  c.data_out       = mdl_peer & DIR_WRITE_MASK;
               end else if (mdl_phase == XFER_WANT_READ) begin
                  c.data_out_valid = 1'b1;
                  c.data_out       = mdl_peer | DIR_READ_BIT;
               end
            end
            ST_SLA_W_ACK, ST_DATA_W_ACK: begin
               if (st == ST_SLA_W_ACK)
                  mdl_phase = XFER_RUNNING;
               if (mdl_left != 8'd0) begin
                  c.data_out_valid = 1'b1;
                  c.data_out       = w.tx_byte;
                  c.buffer_index   = mdl_position;
                  mdl_position     = mdl_position + 8'd1;
                  mdl_left         = mdl_left - 8'd1;
               end else begin
                  // a probe always stops, a finished write stops unless held
                  if (st == ST_SLA_W_ACK || !mdl_no_stop)
                     c.send_stop = 1'b1;
                  mdl_phase = XFER_IDLE;
               end
            end
            ST_SLA_W_NACK, ST_DATA_W_NACK, ST_SLA_R_NACK: begin
               c.send_stop = 1'b1;
               mdl_phase   = XFER_IDLE;
               mdl_nack    = 1'b1;
            end
            ST_ARB_LOST: begin
               c.send_start = 1'b1;
            end
            ST_SLA_R_ACK: begin
               mdl_phase = XFER_RUNNING;
               if (mdl_left > 8'd1)
                  c.ack_next = 1'b1;
            end
            ST_DATA_R_ACK, ST_DATA_R_NACK: begin
               if (mdl_left != 8'd0) begin
                  c.rx_valid     = 1'b1;
                  c.rx_byte_out  = w.rx_byte;
                  c.buffer_index = mdl_position;
                  mdl_position   = mdl_position + 8'd1;
                  mdl_left       = mdl_left - 8'd1;
               end
               if (st == ST_DATA_R_ACK) begin
                  if (mdl_left > 8'd1)
                     c.ack_next = 1'b1;
               end else begin
                  if (!mdl_no_stop)
                     c.send_stop = 1'b1;
                  mdl_phase = XFER_IDLE;
               end
            end
            ST_BUS_ERROR: begin
               c.send_stop = 1'b1;
               c.ack_next  = 1'b1;
               mdl_phase   = XFER_IDLE;
            end
            default: begin
            end
         endcase
      end
      c.busy   = (mdl_phase != XFER_IDLE);
      c.nacked = mdl_nack;
      return c;
   endfunction

   // offer one word, hold it until taken, then maybe leave a gap
   task automatic send_word(req_word_type w);
      req_valid           <= 1'b1;
      req_opcode          <= w.opcode;
      req_target_address  <= w.target_address;
      req_transfer_length <= w.transfer_length;
      req_hold_bus        <= w.hold_bus;
      req_status_code     <= w.status_code;
      req_rx_byte         <= w.rx_byte;
      req_tx_byte         <= w.tx_byte;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_control_words.push_back(next_control_word(w));
      items_sent++;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(0, 99) < sender_idle_pct);
      end
   endtask

   function automatic req_word_type make_start(opcode_type op, logic [7:0] addr,
                                               logic [7:0] len, logic hold);
      req_word_type w;
      w                 = '0;
      w.opcode          = op;
      w.target_address  = addr;
      w.transfer_length = len;
      w.hold_bus        = hold;
      return w;
   endfunction

   function automatic req_word_type make_event(status_type st, logic [7:0] rx,
                                               logic [7:0] tx);
      req_word_type w;
      w             = '0;
      w.opcode      = OP_BUS_EVENT;
      w.status_code = st;
      w.rx_byte     = rx;
      w.tx_byte     = tx;
      return w;
   endfunction

   // every field random, opcode over its full two bits
   function automatic req_word_type random_word();
      req_word_type w;
      w.opcode          = opcode_type'($urandom_range(0, 3));
      w.target_address  = 8'($urandom);
      w.transfer_length = 8'($urandom);
      w.hold_bus        = 1'($urandom);
      w.status_code     = 8'($urandom);
      w.rx_byte         = 8'($urandom);
      w.tx_byte         = 8'($urandom);
      return w;
   endfunction

   // bus event with random data and random don't-care status bits
   function automatic req_word_type bus_event(status_type code);
      req_word_type w;
      w             = random_word();
      w.opcode      = OP_BUS_EVENT;
      w.status_code = code | status_type'($urandom_range(0, 7));
      return w;
   endfunction

   // mostly short transfers, now and then a long one cut short
   function automatic int unsigned pick_length();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
   endfunction

   // usually clear a leftover transfer with a bus error before a new one
   task automatic settle_to_idle();
      if (mdl_phase != XFER_IDLE && $urandom_range(0, 4) != 0)
         send_word(bus_event(ST_BUS_ERROR));
   endtask

   // a start word while busy, which the block drops
   task automatic maybe_stray_start();
      req_word_type w;
      if ($urandom_range(0, 7) == 0) begin
         w        = random_word();
         w.opcode = $urandom_range(0, 1) ? OP_BEGIN_WRITE : OP_BEGIN_READ;
         send_word(w);
      end
   endtask

   task automatic maybe_arbitration_loss();
      if ($urandom_range(0, 5) == 0) begin
         send_word(bus_event(ST_ARB_LOST));
         send_word(bus_event(ST_REP_START));
      end
   endtask

   task automatic run_write_transfer();
      req_word_type w;
      int unsigned  len;
      int unsigned  k;
      settle_to_idle();
      len               = pick_length();
      w                 = random_word();
      w.opcode          = OP_BEGIN_WRITE;
      w.transfer_length = len[7:0];
      send_word(w);
      maybe_stray_start();
      send_word(bus_event($urandom_range(0, 1) ? ST_START : ST_REP_START));
      maybe_arbitration_loss();
      if ($urandom_range(0, 7) == 0) begin
         send_word(bus_event(ST_SLA_W_NACK));
         return;
      end
      k = (len > 6) ? $urandom_range(1, 6) : len;
      // address ack sends the first data byte, or stops a probe
      send_word(bus_event(ST_SLA_W_ACK));
      if (len == 0)
         return;
      repeat (k - 1)
         send_word(bus_event(ST_DATA_W_ACK));
      if (k == len)
         send_word(bus_event(ST_DATA_W_ACK));
      else
         send_word(bus_event($urandom_range(0, 1) ? ST_DATA_W_NACK : ST_BUS_ERROR));
   endtask

   task automatic run_read_transfer();
      req_word_type w;
      int unsigned  len;
      int unsigned  k;
      settle_to_idle();
      len               = pick_length();
      w                 = random_word();
      w.opcode          = OP_BEGIN_READ;
      w.transfer_length = len[7:0];
      send_word(w);
      maybe_stray_start();
      send_word(bus_event($urandom_range(0, 1) ? ST_START : ST_REP_START));
      maybe_arbitration_loss();
      if ($urandom_range(0, 7) == 0) begin
         send_word(bus_event(ST_SLA_R_NACK));
         return;
      end
      send_word(bus_event(ST_SLA_R_ACK));
      k = (len > 6) ? $urandom_range(1, 6) : len;
      if (k > 1)
         repeat (k - 1)
            send_word(bus_event(ST_DATA_R_ACK));
      send_word(bus_event(ST_DATA_R_NACK));
   endtask

   task automatic send_noise();
      req_word_type w;
      w = random_word();
      if (w.opcode == OP_BUS_EVENT && $urandom_range(0, 1))
         w.status_code = known_codes[$urandom_range(0, 12)] |
                         status_type'($urandom_range(0, 7));
      send_word(w);
   endtask

   // zero-length write: address only, then stop; status low bits set
   task automatic test_write_probe();
      send_word(make_start(OP_BEGIN_WRITE, 8'hff, 8'h00, 1'b0));
      send_word(make_event(ST_START, 8'h00, 8'h00));
      send_word(make_event(ST_SLA_W_ACK | 8'h07, 8'hff, 8'hff));
   endtask

   // two-byte write held open, with a read start dropped while busy
   task automatic test_write_hold();
      send_word(make_start(OP_BEGIN_WRITE, 8'h00, 8'h02, 1'b1));
      send_word(make_start(OP_BEGIN_READ, 8'h55, 8'h01, 1'b0));
      send_word(make_event(ST_REP_START, 8'h00, 8'h00));
      send_word(make_event(ST_SLA_W_ACK, 8'h00, 8'hff));
      send_word(make_event(ST_DATA_W_ACK, 8'hff, 8'h00));
      send_word(make_event(ST_DATA_W_ACK, 8'h00, 8'h00));
   endtask

   // read of maximum length with an arbitration loss, ended by a nack
   task automatic test_read_arbitration();
      send_word(make_start(OP_BEGIN_READ, 8'haa, 8'hff, 1'b1));
      send_word(make_event(ST_START, 8'h00, 8'h00));
      send_word(make_event(ST_ARB_LOST, 8'h00, 8'h00));
      send_word(make_event(ST_START, 8'h00, 8'h00));
      send_word(make_event(ST_SLA_R_ACK, 8'h00, 8'h00));
      send_word(make_event(ST_DATA_R_ACK, 8'hff, 8'h00));
      send_word(make_event(ST_DATA_R_NACK, 8'h00, 8'hff));
   endtask

   // data nack, address nack on read, then a bus error while idle
   task automatic test_nack_paths();
      send_word(make_start(OP_BEGIN_WRITE, 8'h5a, 8'h03, 1'b0));
      send_word(make_event(ST_START, 8'h00, 8'h00));
      send_word(make_event(ST_SLA_W_ACK, 8'h00, 8'ha5));
      send_word(make_event(ST_DATA_W_NACK, 8'h00, 8'h00));
      send_word(make_start(OP_BEGIN_READ, 8'h81, 8'h02, 1'b0));
      send_word(make_event(ST_START, 8'h00, 8'h00));
      send_word(make_event(ST_SLA_R_NACK, 8'h00, 8'h00));
      send_word(make_event(ST_BUS_ERROR, 8'h00, 8'h00));
   endtask

   // no-information status, an unlisted status and the unused opcode
   task automatic test_odd_codes();
      send_word(make_event(ST_NO_INFO | 8'h07, 8'hff, 8'hff));
      send_word(make_event(ST_UNLISTED | 8'h07, 8'h00, 8'h00));
      send_word(make_start(OP_UNUSED, 8'hff, 8'hff, 1'b1));
   endtask

   // mostly well-formed transfers with random content, some noise
   task automatic test_random_transfers(int unsigned idle_pct, int unsigned stall_pct,
                                        int unsigned count);
      int unsigned target;
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      target          = items_sent + count;
      while (items_sent < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: run_write_transfer();
            4, 5, 6, 7: run_read_transfer();
            default:    send_noise();
         endcase
      end
   endtask

   // receiver holds off for a long stretch while words keep coming
   task automatic test_backpressure();
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      fork
         begin
            rsp_hold_off <= 1'b1;
            repeat (80)
               @(posedge clock);
            rsp_hold_off <= 1'b0;
         end
         begin
            repeat (4)
               run_read_transfer();
            repeat (4)
               run_write_transfer();
         end
      join
   endtask

   // receiver side: random stalls, or a full hold-off
   always @(posedge clock) begin
      rsp_ready <= !rsp_hold_off && ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
      if (exp_val !== act_val) begin
         mismatch_count++;
         if (mismatch_count <= 40)
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
      end
   endtask

   // every taken result word against the oldest prediction
   always @(posedge clock) begin : result_checker
      ctrl_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_control_words.size() == 0) begin
            mismatch_count++;
            $display("%0t: result word with nothing expected", $time);
         end else begin
            exp_w = pending_control_words.pop_front();
            check_field("control_write", 8'(exp_w.control_write), 8'(rsp_control_write));
            check_field("send_start", 8'(exp_w.send_start), 8'(rsp_send_start));
            check_field("send_stop", 8'(exp_w.send_stop), 8'(rsp_send_stop));
            check_field("ack_next", 8'(exp_w.ack_next), 8'(rsp_ack_next));
            check_field("data_out_valid", 8'(exp_w.data_out_valid),
                        8'(rsp_data_out_valid));
            check_field("data_out", exp_w.data_out, rsp_data_out);
            check_field("rx_valid", 8'(exp_w.rx_valid), 8'(rsp_rx_valid));
            check_field("rx_byte_out", exp_w.rx_byte_out, rsp_rx_byte_out);
            check_field("buffer_index", exp_w.buffer_index, rsp_buffer_index);
            check_field("busy_res", 8'(exp_w.busy), 8'(rsp_busy_res));
            check_field("nacked", 8'(exp_w.nacked), 8'(rsp_nacked));
         end
      end
   end

   initial begin
      repeat (6)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_write_probe();
      test_write_hold();
      test_read_arbitration();
      test_nack_paths();
      test_odd_codes();

      test_random_transfers(0, 0, 95);
      test_random_transfers(77, 0, 95);
      test_random_transfers(0, 77, 95);
      test_random_transfers(31, 31, 95);
      test_backpressure();

      // drain: no more words offered, receiver always ready
      req_valid     <= 1'b0;
      rsp_stall_pct  = 0;
      while (pending_control_words.size() != 0)
         @(posedge clock);
      repeat (10)
         @(posedge clock);

      if (mismatch_count == 0 && pending_control_words.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // run limit far beyond the slowest correct run
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
